// File: design/dhl_pkg.sv
// Shared types and constants for the Denavit-Hartenberg link transform.
// Used by every module of the block; depends on nothing else.
package dhl_pkg;

	// Joint kinds: which link parameter takes the joint value.
	localparam logic [2:0] KIND_FIXED = 3'd0;
	localparam logic [2:0] KIND_ALPHA = 3'd1;
	localparam logic [2:0] KIND_THETA = 3'd2;
	localparam logic [2:0] KIND_R     = 3'd3;
	localparam logic [2:0] KIND_D     = 3'd4;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_D     = 3'd0;
	localparam logic [2:0] REG_THETA = 3'd1;
	localparam logic [2:0] REG_R     = 3'd2;
	localparam logic [2:0] REG_ALPHA = 3'd3;
	localparam logic [2:0] REG_KIND  = 3'd4;

	// Pi in Q61 and the limit CORDIC gain in Q30.
	localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	// Arctangent of 2^-i in Q30.
	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// One result beat.
	typedef struct packed {
		logic signed [31:0] rot_00;
		logic signed [31:0] rot_01;
		logic signed [31:0] rot_02;
		logic signed [31:0] rot_10;
		logic signed [31:0] rot_11;
		logic signed [31:0] rot_12;
		logic signed [31:0] rot_21;
		logic signed [31:0] rot_22;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} result_t;

endpackage

// File: design/dhl_range_reduce.sv
// Angle wrap into [-pi, pi) and fold into [-pi/2, pi/2], one conditional subtract per stage.
// Depends on dhl_pkg for the value of pi.
module dhl_range_reduce #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] ang,
	output logic signed [33:0] z_out,
	output logic               neg_out
);

	localparam longint unsigned PI_F =
		(dhl_pkg::PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
	localparam longint unsigned TWO_PI = 2 * PI_F;
	localparam longint unsigned BIAS = TWO_PI * ((64'd1 << 32) / TWO_PI + 1);
	localparam int STEPS = 33 - FRAC_BITS;
	localparam longint unsigned PI_Z = PI_F << (30 - FRAC_BITS);
	localparam logic signed [35:0] PI_Z_S = 36'(PI_Z);
	localparam logic signed [35:0] HALF_S = 36'(PI_Z >> 1);

	logic [35:0] u0;
	logic [35:0] u_s [STEPS];

	// Shift by pi and a multiple of two pi so that the value is never negative.
	assign u0 = 36'($signed({{3{ang[32]}}, ang})) + 36'(PI_F) + 36'(BIAS);

	// Long-division remainder by two pi, largest multiple first.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [35:0] SUB = 36'(TWO_PI << (STEPS - 1 - k));
		logic [35:0] prev;
		if (k == 0) begin : g_first
			assign prev = u0;
		end else begin : g_next
			assign prev = u_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				u_s[k] <= (prev >= SUB) ? prev - SUB : prev;
			end
		end
	end

	// Recenter, scale to Q30 and fold the outer half-turns.
	logic signed [35:0] zc;
	logic signed [35:0] zf;
	logic               nf;
	always_comb begin
		zc = ($signed(u_s[STEPS-1]) - $signed(36'(PI_F))) <<< (30 - FRAC_BITS);
		zf = zc;
		nf = 1'b0;
		if (zc > HALF_S) begin
			zf = zc - PI_Z_S;
			nf = 1'b1;
		end else if (zc < -HALF_S) begin
			zf = zc + PI_Z_S;
			nf = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_out   <= 34'(zf);
			neg_out <= nf;
		end
	end

endmodule

// File: design/dhl_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per stage, with sign flip and clamp at the end.
// Depends on dhl_pkg for the gain and the arctangent table.
module dhl_cordic #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] z_in,
	input  logic               neg_in,
	output logic signed [31:0] cos_out,
	output logic signed [31:0] sin_out
);

	localparam logic signed [33:0] ONE = 34'sd1073741824;

	logic signed [33:0] x_s [CORDIC_STAGES];
	logic signed [33:0] y_s [CORDIC_STAGES];
	logic signed [33:0] z_s [CORDIC_STAGES];
	logic               n_s [CORDIC_STAGES];

	// One micro-rotation per stage, direction from the sign of the residual angle.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		localparam logic signed [33:0] AT = 34'($signed({1'b0, dhl_pkg::ATAN_Q30[i]}));
		logic signed [33:0] px, py, pz;
		logic               pn;
		if (i == 0) begin : g_first
			assign px = dhl_pkg::GAIN_Q30;
			assign py = '0;
			assign pz = z_in;
			assign pn = neg_in;
		end else begin : g_next
			assign px = x_s[i-1];
			assign py = y_s[i-1];
			assign pz = z_s[i-1];
			assign pn = n_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (pz >= 0) begin
					x_s[i] <= px - (py >>> i);
					y_s[i] <= py + (px >>> i);
					z_s[i] <= pz - AT;
				end else begin
					x_s[i] <= px + (py >>> i);
					y_s[i] <= py - (px >>> i);
					z_s[i] <= pz + AT;
				end
				n_s[i] <= pn;
			end
		end
	end

	// Undo the half-turn fold and clamp to the unit range.
	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > ONE) begin
			r = 32'sd1073741824;
		end else if (v < -ONE) begin
			r = -32'sd1073741824;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

	logic signed [33:0] xf, yf;
	always_comb begin
		xf = n_s[CORDIC_STAGES-1] ? -x_s[CORDIC_STAGES-1] : x_s[CORDIC_STAGES-1];
		yf = n_s[CORDIC_STAGES-1] ? -y_s[CORDIC_STAGES-1] : y_s[CORDIC_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_out <= clamp_unit(xf);
			sin_out <= clamp_unit(yf);
		end
	end

endmodule

// File: design/dhl_matrix.sv
// Products of sines and cosines and the translation: one multiply stage, one rounding stage.
// Depends on dhl_pkg for the result structure.
module dhl_matrix (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] ct,
	input  logic signed [31:0] st,
	input  logic signed [31:0] ca,
	input  logic signed [31:0] sa,
	input  logic signed [32:0] r,
	input  logic signed [32:0] d,
	output dhl_pkg::result_t   res
);

	logic signed [64:0] p01_s1, p02_s1, p11_s1, p12_s1, px_s1, py_s1;
	logic signed [31:0] ct_s1, st_s1, ca_s1, sa_s1;
	logic signed [32:0] d_s1;

	logic signed [32:0] nst, nct;
	assign nst = -33'(st);
	assign nct = -33'(ct);

	// Exact products, formed at the full 65-bit width of the stage register.
	always_ff @(posedge clk) begin
		if (en) begin
			p01_s1 <= nst * 33'(ca);
			p02_s1 <= 33'(st) * 33'(sa);
			p11_s1 <= 33'(ct) * 33'(ca);
			p12_s1 <= nct * 33'(sa);
			px_s1  <= r * 33'(ct);
			py_s1  <= r * 33'(st);
			ct_s1  <= ct;
			st_s1  <= st;
			ca_s1  <= ca;
			sa_s1  <= sa;
			d_s1   <= d;
		end
	end

	// Round half up at bit 30.
	function automatic logic signed [64:0] rnd30(input logic signed [64:0] p);
		return (p + 65'sd536870912) >>> 30;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r32;
		if (v > 65'sd2147483647) begin
			r32 = 32'sh7FFFFFFF;
		end else if (v < -65'sd2147483648) begin
			r32 = 32'sh80000000;
		end else begin
			r32 = 32'(v);
		end
		return r32;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			res.rot_00 <= ct_s1;
			res.rot_01 <= 32'(rnd30(p01_s1));
			res.rot_02 <= 32'(rnd30(p02_s1));
			res.rot_10 <= st_s1;
			res.rot_11 <= 32'(rnd30(p11_s1));
			res.rot_12 <= 32'(rnd30(p12_s1));
			res.rot_21 <= sa_s1;
			res.rot_22 <= ca_s1;
			res.pos_x  <= sat32(rnd30(px_s1));
			res.pos_y  <= sat32(rnd30(py_s1));
			res.pos_z  <= sat32(65'(d_s1));
		end
	end

endmodule

// File: design/dh_link_transform.sv
// Top level of the Denavit-Hartenberg link transform: registers, entry stage, delay line, skid.
// Depends on dhl_pkg, dhl_range_reduce, dhl_cordic and dhl_matrix.
//
//   channel   handshake             payload
//   in        in_valid / in_ready   joint_value
//   out       out_valid / out_ready rot_00..rot_22, pos_x, pos_y, pos_z
//   config    APB psel/penable      paddr, pwdata, prdata
//
// One beat enters per cycle while in_ready is high; the pipeline depth is set by one remainder
// step per stage in the angle wrap and one rotation per CORDIC stage.
// Reset clears the configuration registers and every valid bit.
// A stalled output beat goes into a skid register; in_ready falls only while it is full,
// and then the whole pipeline holds.
module dh_link_transform #(
	parameter int CORDIC_STAGES = 16,
	parameter int FRAC_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] joint_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] rot_00,
	output logic signed [31:0] rot_01,
	output logic signed [31:0] rot_02,
	output logic signed [31:0] rot_10,
	output logic signed [31:0] rot_11,
	output logic signed [31:0] rot_12,
	output logic signed [31:0] rot_21,
	output logic signed [31:0] rot_22,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z
);

	localparam int DLY = (33 - FRAC_BITS) + 1 + CORDIC_STAGES + 1;
	localparam int VLEN = DLY + 2;

	// Configuration registers.
	logic signed [31:0] d_q, theta_q, r_q, alpha_q;
	logic [2:0]         kind_q;
	logic [2:0]         ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q     <= '0;
			theta_q <= '0;
			r_q     <= '0;
			alpha_q <= '0;
			kind_q  <= dhl_pkg::KIND_FIXED;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				dhl_pkg::REG_D:     d_q     <= pwdata;
				dhl_pkg::REG_THETA: theta_q <= pwdata;
				dhl_pkg::REG_R:     r_q     <= pwdata;
				dhl_pkg::REG_ALPHA: alpha_q <= pwdata;
				dhl_pkg::REG_KIND:  kind_q  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			dhl_pkg::REG_D:     prdata = d_q;
			dhl_pkg::REG_THETA: prdata = theta_q;
			dhl_pkg::REG_R:     prdata = r_q;
			dhl_pkg::REG_ALPHA: prdata = alpha_q;
			dhl_pkg::REG_KIND:  prdata = {29'd0, kind_q};
			default:            prdata = '0;
		endcase
	end

	// Pipeline advance, held only while the skid register is occupied.
	logic en;
	logic skid_v_q;
	assign en       = !skid_v_q;
	assign in_ready = en;

	// Entry stage: add the joint value to the selected parameter.
	logic signed [32:0] q33, d_e, t_e, r_e, a_e;
	always_comb begin
		q33 = 33'(joint_value);
		d_e = 33'(d_q);
		t_e = 33'(theta_q);
		r_e = 33'(r_q);
		a_e = 33'(alpha_q);
		unique case (kind_q)
			dhl_pkg::KIND_ALPHA: a_e = 33'(alpha_q) + q33;
			dhl_pkg::KIND_THETA: t_e = 33'(theta_q) + q33;
			dhl_pkg::KIND_R:     r_e = 33'(r_q) + q33;
			dhl_pkg::KIND_D:     d_e = 33'(d_q) + q33;
			default: ;
		endcase
	end

	logic signed [32:0] d_s1, t_s1, r_s1, a_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_e;
			t_s1 <= t_e;
			r_s1 <= r_e;
			a_s1 <= a_e;
		end
	end

	// Valid bits travel beside the data.
	logic v_s1;
	logic v_s [VLEN];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < VLEN; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1   <= in_valid;
			v_s[0] <= v_s1;
			for (int i = 1; i < VLEN; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	// Length and offset wait beside the sine and cosine lanes.
	logic signed [32:0] r_d [DLY];
	logic signed [32:0] d_d [DLY];
	always_ff @(posedge clk) begin
		if (en) begin
			r_d[0] <= r_s1;
			d_d[0] <= d_s1;
			for (int i = 1; i < DLY; i++) begin
				r_d[i] <= r_d[i-1];
				d_d[i] <= d_d[i-1];
			end
		end
	end

	// Two angle lanes.
	logic signed [33:0] zt, za;
	logic               nt, na;
	logic signed [31:0] ct, st, ca, sa;

	dhl_range_reduce #(.FRAC_BITS(FRAC_BITS)) u_wrap_t (
		.clk(clk), .en(en), .ang(t_s1), .z_out(zt), .neg_out(nt)
	);
	dhl_range_reduce #(.FRAC_BITS(FRAC_BITS)) u_wrap_a (
		.clk(clk), .en(en), .ang(a_s1), .z_out(za), .neg_out(na)
	);
	dhl_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_t (
		.clk(clk), .en(en), .z_in(zt), .neg_in(nt), .cos_out(ct), .sin_out(st)
	);
	dhl_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_a (
		.clk(clk), .en(en), .z_in(za), .neg_in(na), .cos_out(ca), .sin_out(sa)
	);

	dhl_pkg::result_t res_last;
	dhl_matrix u_matrix (
		.clk(clk), .en(en), .ct(ct), .st(st), .ca(ca), .sa(sa),
		.r(r_d[DLY-1]), .d(d_d[DLY-1]), .res(res_last)
	);

	// Output register and skid register.
	dhl_pkg::result_t out_q, skid_q;
	logic             out_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			out_v_q  <= skid_v_q || v_s[VLEN-1];
			skid_v_q <= 1'b0;
		end else if (en && v_s[VLEN-1]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res_last;
		end else if (en && v_s[VLEN-1]) begin
			skid_q <= res_last;
		end
	end

	assign out_valid = out_v_q;
	assign rot_00    = out_q.rot_00;
	assign rot_01    = out_q.rot_01;
	assign rot_02    = out_q.rot_02;
	assign rot_10    = out_q.rot_10;
	assign rot_11    = out_q.rot_11;
	assign rot_12    = out_q.rot_12;
	assign rot_21    = out_q.rot_21;
	assign rot_22    = out_q.rot_22;
	assign pos_x     = out_q.pos_x;
	assign pos_y     = out_q.pos_y;
	assign pos_z     = out_q.pos_z;

endmodule
